[design/gdad_pkg.sv]
// ----------------------------------------------------------------------------
// gdad_pkg: shared types, constants and microcode for the date adder
// Holds the item structs, calendar constants, the month length function and
// the control store that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gdad_pkg;

  // Field widths
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffsW   = 16;
  localparam int unsigned StatW   = 2;
  // Day count within a year plus the largest offset fits in 17 bits
  localparam int unsigned RemW    = 17;
  localparam int unsigned YLenW   = 9;
  localparam int unsigned PcW     = 4;

  localparam logic [YearW-1:0]  YearMax   = YearW'(9999);
  localparam logic [YearW-1:0]  YearCycle = YearW'(400);
  localparam logic [8:0]        CycleLast = 9'd399;
  localparam logic [MonthW-1:0] MonthLast = MonthW'(12);
  localparam logic [DayW-1:0]   DayLast   = DayW'(31);
  localparam logic [YLenW-1:0]  LeapLen   = YLenW'(366);
  localparam logic [YLenW-1:0]  NormLen   = YLenW'(365);

  // Result status codes
  localparam logic [StatW-1:0] StOk   = 2'd0;
  localparam logic [StatW-1:0] StBad  = 2'd1;
  localparam logic [StatW-1:0] StOvf  = 2'd2;

  typedef struct packed {
    logic [YearW-1:0]  year_in;
    logic [MonthW-1:0] month_in;
    logic [DayW-1:0]   day_in;
    logic [OffsW-1:0]  days_to_add;
  } in_item_t;

  typedef struct packed {
    logic [YearW-1:0]  year_out;
    logic [MonthW-1:0] month_out;
    logic [DayW-1:0]   day_out;
    logic [StatW-1:0]  status;
  } out_item_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED400,
    OP_ACC_MONTH,
    OP_ADD_N,
    OP_YEAR_STEP,
    OP_MON_STEP,
    OP_OUT_OK,
    OP_OUT_OVF,
    OP_OUT_BAD
  } op_e;

  // Branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_START,
    C_R400_LT,
    C_BAD_DATE,
    C_MI_GE_M,
    C_YEAR_EXIT,
    C_REM_LT_YLEN,
    C_MON_EXIT
  } cond_e;

  // One control word
  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           hold;
  } ucode_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic start;
    logic r400_lt;
    logic bad_date;
    logic mi_ge_m;
    logic year_exit;
    logic rem_lt_ylen;
    logic mon_exit;
  } flags_t;

  // Step addresses
  localparam logic [PcW-1:0] PcIdle  = 4'd0;
  localparam logic [PcW-1:0] PcRed   = 4'd1;
  localparam logic [PcW-1:0] PcChk   = 4'd2;
  localparam logic [PcW-1:0] PcAcc   = 4'd3;
  localparam logic [PcW-1:0] PcAddN  = 4'd4;
  localparam logic [PcW-1:0] PcYear  = 4'd5;
  localparam logic [PcW-1:0] PcYSplt = 4'd6;
  localparam logic [PcW-1:0] PcOvf   = 4'd7;
  localparam logic [PcW-1:0] PcMon   = 4'd8;
  localparam logic [PcW-1:0] PcOk    = 4'd9;
  localparam logic [PcW-1:0] PcBad   = 4'd10;

  // Days in a month; codes outside 1..12 give zero
  function automatic logic [DayW-1:0] month_len(input logic leap,
                                                input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Control store
  function automatic ucode_t ucode(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      PcIdle:  w = '{op: OP_LOAD,      cond: C_NO_START,    target: PcIdle,  hold: 1'b0};
      PcRed:   w = '{op: OP_RED400,    cond: C_R400_LT,     target: PcChk,   hold: 1'b1};
      PcChk:   w = '{op: OP_NONE,      cond: C_BAD_DATE,    target: PcBad,   hold: 1'b0};
      PcAcc:   w = '{op: OP_ACC_MONTH, cond: C_MI_GE_M,     target: PcAddN,  hold: 1'b1};
      PcAddN:  w = '{op: OP_ADD_N,     cond: C_ALWAYS,      target: PcYear,  hold: 1'b0};
      PcYear:  w = '{op: OP_YEAR_STEP, cond: C_YEAR_EXIT,   target: PcYSplt, hold: 1'b1};
      PcYSplt: w = '{op: OP_NONE,      cond: C_REM_LT_YLEN, target: PcMon,   hold: 1'b0};
      PcOvf:   w = '{op: OP_OUT_OVF,   cond: C_ALWAYS,      target: PcIdle,  hold: 1'b0};
      PcMon:   w = '{op: OP_MON_STEP,  cond: C_MON_EXIT,    target: PcOk,    hold: 1'b1};
      PcOk:    w = '{op: OP_OUT_OK,    cond: C_ALWAYS,      target: PcIdle,  hold: 1'b0};
      PcBad:   w = '{op: OP_OUT_BAD,   cond: C_ALWAYS,      target: PcIdle,  hold: 1'b0};
      default: w = '{op: OP_NONE,      cond: C_ALWAYS,      target: PcIdle,  hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/gdad_seq.sv]
// ----------------------------------------------------------------------------
// gdad_seq: microcode sequencer
// Step counter over the control store with conditional jumps and a hold bit
// that lets one step loop on itself until its exit condition holds.
// ----------------------------------------------------------------------------
`default_nettype none

module gdad_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gdad_pkg::flags_t flags_i,
  output gdad_pkg::ucode_t     uc_o,
  output logic                 busy_o
);

  logic [gdad_pkg::PcW-1:0] pc_q, pc_d;
  gdad_pkg::ucode_t         uc;
  logic                     taken;

  // Fetch the control word for this step
  assign uc     = gdad_pkg::ucode(pc_q);
  assign uc_o   = uc;
  assign busy_o = (pc_q != gdad_pkg::PcIdle);

  // Select the branch condition
  always_comb begin
    unique case (uc.cond)
      gdad_pkg::C_ALWAYS:      taken = 1'b1;
      gdad_pkg::C_NO_START:    taken = !flags_i.start;
      gdad_pkg::C_R400_LT:     taken = flags_i.r400_lt;
      gdad_pkg::C_BAD_DATE:    taken = flags_i.bad_date;
      gdad_pkg::C_MI_GE_M:     taken = flags_i.mi_ge_m;
      gdad_pkg::C_YEAR_EXIT:   taken = flags_i.year_exit;
      gdad_pkg::C_REM_LT_YLEN: taken = flags_i.rem_lt_ylen;
      gdad_pkg::C_MON_EXIT:    taken = flags_i.mon_exit;
      default:                 taken = 1'b1;
    endcase
  end

  // Jump, hold or advance
  always_comb begin
    priority if (taken) begin
      pc_d = uc.target;
    end else if (uc.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= gdad_pkg::PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

[design/gregorian_date_add_days.sv]
// ----------------------------------------------------------------------------
// gregorian_date_add_days: Gregorian date plus a day offset
// Microcoded datapath that walks years and months forward from a start date.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start while busy is low; the item is taken at that
//   clock edge and busy rises on the next cycle. Exactly one result follows:
//   result_o is valid for a single cycle, marked by valid_o, in the cycle in
//   which busy has just fallen. The receiver cannot stall; results must be
//   taken when shown.
//   A run reduces the start year modulo 400, checks the start date, adds the
//   months before the start month and then the offset to the day count,
//   steps off whole years and then the whole months of the final year.
//   An invalid start date is answered once the modulo-400 reduction is done.
//   One item at a time: the next item is taken once busy is low again.
//   Status: 0 ok, 1 invalid start date (fields zero), 2 past year 9999
//   (fields saturated to 9999-12-31).
//   Reset returns the sequencer to idle and clears valid_o.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_add_days (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire gdad_pkg::in_item_t  item_i,
  output logic                     valid_o,
  output gdad_pkg::out_item_t      result_o
);

  localparam int unsigned YearW  = gdad_pkg::YearW;
  localparam int unsigned MonthW = gdad_pkg::MonthW;
  localparam int unsigned DayW   = gdad_pkg::DayW;
  localparam int unsigned OffsW  = gdad_pkg::OffsW;
  localparam int unsigned RemW   = gdad_pkg::RemW;
  localparam int unsigned YLenW  = gdad_pkg::YLenW;

  gdad_pkg::ucode_t  uc;
  gdad_pkg::flags_t  flags;

  logic [YearW-1:0]  year_q, year_d;
  logic [YearW-1:0]  ymod_q, ymod_d;   // year modulo 400 once reduced
  logic [MonthW-1:0] mon_q, mon_d;     // start month
  logic [DayW-1:0]   day_q, day_d;
  logic [OffsW-1:0]  offs_q, offs_d;
  logic [MonthW-1:0] mi_q, mi_d;       // month walker
  logic [RemW-1:0]   rem_q, rem_d;     // zero-based day count
  logic              valid_q, valid_d;
  gdad_pkg::out_item_t res_q, res_d;

  logic [8:0]        ymod_lo;
  logic              leap;
  logic [YLenW-1:0]  ylen;
  logic [DayW-1:0]   mlen_mi;
  logic [DayW-1:0]   mlen_in;

  gdad_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uc_o    (uc),
    .busy_o  (busy)
  );

  // Leap test from the year's place in the 400-year cycle
  assign ymod_lo = ymod_q[8:0];
  assign leap    = (ymod_lo[1:0] == 2'b00) && (ymod_lo != 9'd100) &&
                   (ymod_lo != 9'd200) && (ymod_lo != 9'd300);
  assign ylen    = leap ? gdad_pkg::LeapLen : gdad_pkg::NormLen;
  assign mlen_mi = gdad_pkg::month_len(leap, mi_q);
  assign mlen_in = gdad_pkg::month_len(leap, mon_q);

  // Conditions for the sequencer
  always_comb begin
    flags.start       = start;
    flags.r400_lt     = (ymod_q < gdad_pkg::YearCycle);
    flags.bad_date    = (year_q > gdad_pkg::YearMax) || (mon_q == '0) ||
                        (mon_q > gdad_pkg::MonthLast) || (day_q == '0) ||
                        (day_q > mlen_in);
    flags.mi_ge_m     = (mi_q >= mon_q);
    flags.rem_lt_ylen = (rem_q < RemW'(ylen));
    flags.year_exit   = flags.rem_lt_ylen || (year_q == gdad_pkg::YearMax);
    flags.mon_exit    = (mi_q >= gdad_pkg::MonthLast) || (rem_q < RemW'(mlen_mi));
  end

  // Datapath actions; the load and each holding step are guarded by the inverse of their step's exit
  always_comb begin
    year_d  = year_q;
    ymod_d  = ymod_q;
    mon_d   = mon_q;
    day_d   = day_q;
    offs_d  = offs_q;
    mi_d    = mi_q;
    rem_d   = rem_q;
    res_d   = res_q;
    valid_d = 1'b0;
    unique case (uc.op)
      gdad_pkg::OP_LOAD: begin
        if (start) begin
          year_d = item_i.year_in;
          ymod_d = item_i.year_in;
          mon_d  = item_i.month_in;
          day_d  = item_i.day_in;
          offs_d = item_i.days_to_add;
          mi_d   = MonthW'(1);
          rem_d  = RemW'(item_i.day_in) - RemW'(1);
        end
      end
      gdad_pkg::OP_RED400: begin
        if (!flags.r400_lt) begin
          ymod_d = ymod_q - gdad_pkg::YearCycle;
        end
      end
      gdad_pkg::OP_ACC_MONTH: begin
        if (!flags.mi_ge_m) begin
          rem_d = rem_q + RemW'(mlen_mi);
          mi_d  = mi_q + 1'b1;
        end
      end
      gdad_pkg::OP_ADD_N: begin
        rem_d = rem_q + RemW'(offs_q);
        mi_d  = MonthW'(1);
      end
      gdad_pkg::OP_YEAR_STEP: begin
        if (!flags.year_exit) begin
          rem_d  = rem_q - RemW'(ylen);
          year_d = year_q + 1'b1;
          ymod_d = (ymod_lo == gdad_pkg::CycleLast) ? '0 : ymod_q + 1'b1;
        end
      end
      gdad_pkg::OP_MON_STEP: begin
        if (!flags.mon_exit) begin
          rem_d = rem_q - RemW'(mlen_mi);
          mi_d  = mi_q + 1'b1;
        end
      end
      gdad_pkg::OP_OUT_OK: begin
        res_d.year_out  = year_q;
        res_d.month_out = mi_q;
        res_d.day_out   = rem_q[DayW-1:0] + DayW'(1);
        res_d.status    = gdad_pkg::StOk;
        valid_d         = 1'b1;
      end
      gdad_pkg::OP_OUT_OVF: begin
        res_d.year_out  = gdad_pkg::YearMax;
        res_d.month_out = gdad_pkg::MonthLast;
        res_d.day_out   = gdad_pkg::DayLast;
        res_d.status    = gdad_pkg::StOvf;
        valid_d         = 1'b1;
      end
      gdad_pkg::OP_OUT_BAD: begin
        res_d.year_out  = '0;
        res_d.month_out = '0;
        res_d.day_out   = '0;
        res_d.status    = gdad_pkg::StBad;
        valid_d         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    year_q <= year_d;
    ymod_q <= ymod_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    offs_q <= offs_d;
    mi_q   <= mi_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  // A result only appears once the sequencer is back at idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always starts a run
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  // Only the defined status codes are reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.status == gdad_pkg::StOk ||
                 result_o.status == gdad_pkg::StBad ||
                 result_o.status == gdad_pkg::StOvf))
    else $error("undefined status code");

  // The month walker never passes December
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (mi_q <= gdad_pkg::MonthLast))
    else $error("month walker out of range");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gregorian_date_add_days
// Sends start dates with day offsets through the start/busy handshake, starting
// with a table of calendar corner cases and going on to random dates. A local
// calendar model predicts each answer the table does not give; every strobed
// result is compared field by field, in order, with the oldest queued answer.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned RandItems  = 1150;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 300;

  typedef struct {
    gdad_pkg::in_item_t  stim;
    bit                  typed;
    gdad_pkg::out_item_t want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  gdad_pkg::in_item_t  item_i;
  logic                valid_o;
  gdad_pkg::out_item_t result_o;

  // Expected dates waiting for their result, oldest first
  gdad_pkg::out_item_t pending_dates[$];
  dir_row_t            dir_rows[$];
  // Set by the sender: answer typed into the table for the item on offer
  bit                  use_typed;
  gdad_pkg::out_item_t typed_want;
  int unsigned         n_taken  = 0;
  int unsigned         n_ok     = 0;
  int unsigned         n_bad    = 0;
  int unsigned         n_ovf    = 0;
  int unsigned         n_errors = 0;
  int unsigned         n_cycles = 0;
  bit                  idle_on;

  gregorian_date_add_days DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar model
  // ---------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  // Month must be 1..12
  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = is_leap(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic gdad_pkg::out_item_t date_after(gdad_pkg::in_item_t it);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned doy;
    int unsigned mi;
    gdad_pkg::out_item_t r;
    y = it.year_in;
    m = it.month_in;
    d = it.day_in;
    r = '0;
    // Reject a start date that does not exist
    if (y > gdad_pkg::YearMax || m < 1 || m > 12 || d < 1 ||
        d > days_in_month(y, m)) begin
      r.status = gdad_pkg::StBad;
      return r;
    end
    // Day within the start year plus the offset
    doy = d - 1;
    for (mi = 1; mi < m; mi++) doy += days_in_month(y, mi);
    doy += it.days_to_add;
    // Advance whole years, saturate past the last year
    while (doy >= days_in_year(y)) begin
      doy -= days_in_year(y);
      y++;
      if (y > gdad_pkg::YearMax) begin
        r.year_out  = gdad_pkg::YearMax;
        r.month_out = gdad_pkg::MonthLast;
        r.day_out   = gdad_pkg::DayLast;
        r.status    = gdad_pkg::StOvf;
        return r;
      end
    end
    // Advance whole months in the final year
    m = 1;
    while (m < 12 && doy >= days_in_month(y, m)) begin
      doy -= days_in_month(y, m);
      m++;
    end
    r.year_out  = gdad_pkg::YearW'(y);
    r.month_out = gdad_pkg::MonthW'(m);
    r.day_out   = gdad_pkg::DayW'(doy + 1);
    r.status    = gdad_pkg::StOk;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic gdad_pkg::in_item_t make_date(int unsigned y, int unsigned m,
                                                   int unsigned d, int unsigned n);
    gdad_pkg::in_item_t it;
    it.year_in     = gdad_pkg::YearW'(y);
    it.month_in    = gdad_pkg::MonthW'(m);
    it.day_in      = gdad_pkg::DayW'(d);
    it.days_to_add = gdad_pkg::OffsW'(n);
    return it;
  endfunction

  function automatic dir_row_t row(int unsigned y, int unsigned m, int unsigned d,
                                   int unsigned n, bit t, int unsigned wy,
                                   int unsigned wm, int unsigned wd,
                                   logic [gdad_pkg::StatW-1:0] ws);
    dir_row_t r;
    r.stim           = make_date(y, m, d, n);
    r.typed          = t;
    r.want.year_out  = gdad_pkg::YearW'(wy);
    r.want.month_out = gdad_pkg::MonthW'(wm);
    r.want.day_out   = gdad_pkg::DayW'(wd);
    r.want.status    = ws;
    return r;
  endfunction

  function automatic gdad_pkg::in_item_t raw_item();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(gdad_pkg::in_item_t)-1:0];
  endfunction

  // Mostly real dates with random offsets, some noise and boundary-heavy picks
  function automatic gdad_pkg::in_item_t rand_date();
    int unsigned sel;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 10) return raw_item();
    m = $urandom_range(1, 12);
    if (sel < 25) y = $urandom_range(9800, 9999);
    else if (sel < 35) y = 400 * $urandom_range(0, 24) + $urandom_range(0, 4) * 100;
    else y = $urandom_range(0, 9999);
    if (sel >= 35 && sel < 55) d = days_in_month(y, m) - $urandom_range(0, 1);
    else d = $urandom_range(1, days_in_month(y, m));
    if (sel >= 25 && sel < 60) n = $urandom_range(0, 800);
    else n = $urandom_range(0, 65535);
    return make_date(y, m, d, n);
  endfunction

  // Offer one item until it is taken, idling at random while waiting
  task automatic send_date(gdad_pkg::in_item_t it, bit t, gdad_pkg::out_item_t want);
    int unsigned target;
    target = n_taken + 1;
    while (n_taken != target) begin
      if (idle_on && $urandom_range(0, 99) < 34) begin
        start  = 1'b0;
        item_i = raw_item();
      end else begin
        start      = 1'b1;
        item_i     = it;
        use_typed  = t;
        typed_want = want;
      end
      @(negedge clk_i);
    end
  endtask

  // Hold off until every pending date has come back
  task automatic drain_dates();
    start = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: take results, then record newly taken items
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gdad_pkg::out_item_t want;
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni) begin
      if (valid_o) begin
        case (result_o.status)
          gdad_pkg::StOk:  n_ok++;
          gdad_pkg::StBad: n_bad++;
          default:         n_ovf++;
        endcase
        if (pending_dates.size() == 0) begin
          $error("result with no item pending: %p", result_o);
          n_errors++;
        end else begin
          want = pending_dates.pop_front();
          if (result_o.year_out !== want.year_out) begin
            $error("year_out: expected %0d, got %0d", want.year_out, result_o.year_out);
            n_errors++;
          end
          if (result_o.month_out !== want.month_out) begin
            $error("month_out: expected %0d, got %0d", want.month_out, result_o.month_out);
            n_errors++;
          end
          if (result_o.day_out !== want.day_out) begin
            $error("day_out: expected %0d, got %0d", want.day_out, result_o.day_out);
            n_errors++;
          end
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_o.status);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_dates.push_back(use_typed ? typed_want : date_after(item_i));
        n_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;
    gdad_pkg::out_item_t none;
    none       = '0;
    use_typed  = 1'b0;
    typed_want = '0;
    idle_on    = 1'b1;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;

    // Calendar corner cases
    dir_rows.push_back(row(2024, 1, 1, 0, 1, 2024, 1, 1, gdad_pkg::StOk));
    dir_rows.push_back(row(0, 1, 1, 0, 1, 0, 1, 1, gdad_pkg::StOk));
    dir_rows.push_back(row(9999, 12, 31, 0, 1, 9999, 12, 31, gdad_pkg::StOk));
    dir_rows.push_back(row(9999, 12, 31, 1, 1, 9999, 12, 31, gdad_pkg::StOvf));
    dir_rows.push_back(row(9999, 12, 31, 65535, 1, 9999, 12, 31, gdad_pkg::StOvf));
    dir_rows.push_back(row(9999, 1, 1, 364, 1, 9999, 12, 31, gdad_pkg::StOk));
    dir_rows.push_back(row(9999, 1, 1, 365, 1, 9999, 12, 31, gdad_pkg::StOvf));
    dir_rows.push_back(row(0, 1, 1, 65535, 0, 0, 0, 0, gdad_pkg::StOk));
    dir_rows.push_back(row(9900, 1, 1, 65535, 0, 0, 0, 0, gdad_pkg::StOk));
    // Start dates that do not exist
    dir_rows.push_back(row(10000, 1, 1, 0, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(16383, 15, 31, 65535, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(2023, 0, 10, 5, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(2023, 13, 1, 5, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(2023, 1, 0, 5, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(2023, 2, 29, 0, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(1900, 2, 29, 0, 1, 0, 0, 0, gdad_pkg::StBad));
    dir_rows.push_back(row(2023, 4, 31, 0, 1, 0, 0, 0, gdad_pkg::StBad));
    // Leap days and month ends
    dir_rows.push_back(row(2024, 2, 29, 0, 1, 2024, 2, 29, gdad_pkg::StOk));
    dir_rows.push_back(row(2000, 2, 29, 0, 1, 2000, 2, 29, gdad_pkg::StOk));
    dir_rows.push_back(row(2023, 1, 31, 0, 1, 2023, 1, 31, gdad_pkg::StOk));
    dir_rows.push_back(row(2023, 12, 31, 1, 0, 0, 0, 0, gdad_pkg::StOk));
    dir_rows.push_back(row(2024, 2, 28, 1, 0, 0, 0, 0, gdad_pkg::StOk));
    dir_rows.push_back(row(1900, 2, 28, 1, 0, 0, 0, 0, gdad_pkg::StOk));
    dir_rows.push_back(row(2000, 2, 28, 1, 0, 0, 0, 0, gdad_pkg::StOk));
    dir_rows.push_back(row(1999, 12, 31, 366, 0, 0, 0, 0, gdad_pkg::StOk));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_date(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    drain_dates();

    // Random dates; one long stretch runs back to back
    for (k = 0; k < RandItems; k++) begin
      idle_on = !(k >= 400 && k < 650);
      send_date(rand_date(), 1'b0, none);
      if (k == 800 || $urandom_range(0, 99) == 0) drain_dates();
    end

    drain_dates();
    repeat (DrainWait) @(negedge clk_i);

    $display("Ran %0d dates through the adder in %0d cycles, table corners included.",
             n_taken, n_cycles);
    $display("Results: %0d in range, %0d invalid start dates, %0d saturated at the top.",
             n_ok, n_bad, n_ovf);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/gdad_pkg.sv
design/gdad_seq.sv
design/gregorian_date_add_days.sv
dv/tb.sv
